>>> hw/rtl/pfr_pkg.sv
// Package for the pixel format unpacker: payload types, format codes, tables, half widening.
`default_nettype none
package pfr_pkg;

  localparam int unsigned FMT_W = 4;
  localparam logic [31:0] ONE_BITS = 32'h3F80_0000;

  typedef enum logic [FMT_W-1:0] {
    FMT_GRAY8      = 4'd0,
    FMT_GRAY_ALPHA = 4'd1,
    FMT_R5G6B5     = 4'd2,
    FMT_R8G8B8     = 4'd3,
    FMT_R5G5B5A1   = 4'd4,
    FMT_R4G4B4A4   = 4'd5,
    FMT_RGBA8      = 4'd6,
    FMT_R32        = 4'd7,
    FMT_RGB32      = 4'd8,
    FMT_RGBA32     = 4'd9,
    FMT_R16        = 4'd10,
    FMT_RGB16      = 4'd11,
    FMT_RGBA16     = 4'd12
  } fmt_t;

  typedef struct packed {
    logic [63:0] pixel_high;
    logic [63:0] pixel_low;
  } pixel_t;

  typedef struct packed {
    logic [31:0] alpha;
    logic [31:0] blue;
    logic [31:0] green;
    logic [31:0] red;
  } rgba_t;

  typedef logic [31:0] tbl256_t [256];
  typedef logic [31:0] tbl64_t  [64];

  // Round x * 2^-e to single precision, nearest even; the lsb of x may carry a sticky bit.
  function automatic logic [31:0] to_float(logic [63:0] x, int e);
    int          p;
    int          d;
    int          bexp;
    logic [63:0] keep;
    logic [63:0] rem;
    logic [63:0] half;
    p = -1;
    for (int i = 0; i < 64; i++) begin
      if (x[i]) p = i;
    end
    if (p < 0) return 32'h0;
    bexp = p - e + 127;
    if (p > 23) begin
      d    = p - 23;
      keep = x >> d;
      rem  = x & ((64'h1 << d) - 64'h1);
      half = 64'h1 << (d - 1);
      if (rem > half || (rem == half && keep[0])) keep = keep + 64'h1;
      if (keep[24]) begin
        keep = keep >> 1;
        bexp = bexp + 1;
      end
    end else begin
      keep = x << (23 - p);
    end
    return {1'b0, 8'(bexp), keep[22:0]};
  endfunction

  function automatic tbl256_t build_div255();
    tbl256_t     t;
    logic [63:0] num;
    logic [63:0] q;
    for (int v = 0; v < 256; v++) begin
      num = 64'(v) << 40;
      q   = num / 255;
      if (num % 255 != 0) q = q | 64'h1;
      t[v] = to_float(q, 40);
    end
    return t;
  endfunction

  // float(v) * float(1/n) rounded, for v below 64.
  function automatic tbl64_t build_scale(int n);
    tbl64_t      t;
    logic [63:0] num;
    logic [63:0] q;
    logic [31:0] rc;
    logic [63:0] mant;
    int          uexp;
    num = 64'h1 << 40;
    q   = num / 64'(n);
    if (num % 64'(n) != 0) q = q | 64'h1;
    rc   = to_float(q, 40);
    mant = {40'h0, 1'b1, rc[22:0]};
    uexp = int'(rc[30:23]) - 127;
    for (int v = 0; v < 64; v++) begin
      t[v] = to_float(64'(v) * mant, 23 - uexp);
    end
    return t;
  endfunction

  localparam tbl256_t DIV255_TBL = build_div255();
  localparam tbl64_t  SCALE15_TBL = build_scale(15);
  localparam tbl64_t  SCALE31_TBL = build_scale(31);
  localparam tbl64_t  SCALE63_TBL = build_scale(63);

  // Half to single; all-ones exponent is rebiased like any other.
  function automatic logic [31:0] half_to_single(logic [15:0] h);
    logic [4:0]  ex;
    logic [9:0]  m;
    logic [3:0]  p;
    logic        any;
    logic [9:0]  nm;
    logic [31:0] r;
    ex  = h[14:10];
    m   = h[9:0];
    p   = 4'd0;
    any = 1'b0;
    for (int i = 0; i < 10; i++) begin
      if (m[i]) begin
        p   = 4'(i);
        any = 1'b1;
      end
    end
    r = {h[15], 31'h0};
    if (ex != 5'd0) begin
      r[30:23] = 8'(ex) + 8'd112;
      r[22:13] = m;
    end else if (any) begin
      nm       = m << (4'd10 - p);
      r[30:23] = 8'(p) + 8'd103;
      r[22:13] = nm;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/pixel_format_to_rgba_float.sv
// Top level: format register, input register, unpack logic and result register.
// Usage:
//  - in channel (in_valid/in_ready/in_data) carries one pixel per transfer:
//    pixel_low holds bits 0..63, pixel_high bits 64..127.
//  - out channel (out_valid/out_ready/out_data) returns red, green, blue and
//    alpha as single-precision bit patterns, one result per pixel, in order.
//  - cfg channel (cfg_valid/cfg_ready/cfg_data) writes the 4-bit format code;
//    cfg_ready is always high. Write it only while the block holds no pixel.
// Path: an input transfer loads the input register; the result register behind
//  the table lookups then loads the result and raises out_valid.
// Throughput: one pixel per cycle; each stage moves whenever the stage after
//  it is empty or is handing its item on in the same cycle.
// Reset (synchronous, rst high): both stages empty, format = gray8.
// Receiver stall: the result register holds its data, the input register
//  fills behind it, then in_ready drops until out_ready returns.
`default_nettype none
module pixel_format_to_rgba_float (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire pfr_pkg::pixel_t             in_data,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output pfr_pkg::rgba_t                   out_data,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [pfr_pkg::FMT_W-1:0]   cfg_data
);
  import pfr_pkg::*;

  logic [FMT_W-1:0] fmt;
  logic             s1_valid;
  pixel_t           s1_pix;
  rgba_t            s1_res;
  logic             adv2;
  logic             adv1;

  // stage 2 can load when empty or draining; stage 1 likewise
  assign adv2      = !out_valid || out_ready;
  assign adv1      = !s1_valid || adv2;
  assign in_ready  = adv1;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      fmt <= FMT_GRAY8;
    end else if (cfg_valid) begin
      fmt <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv1) begin
      s1_valid <= in_valid;
    end
    if (adv1 && in_valid) s1_pix <= in_data;
  end

  pfr_unpack u_unpack (
    .fmt (fmt),
    .pix (s1_pix),
    .res (s1_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv2) begin
      out_valid <= s1_valid;
    end
    if (adv2 && s1_valid) out_data <= s1_res;
  end
endmodule
`default_nettype wire

>>> hw/rtl/pfr_unpack.sv
// Combinational unpack of one pixel into four single-precision components.
`default_nettype none
module pfr_unpack (
  input  wire logic [pfr_pkg::FMT_W-1:0] fmt,
  input  wire pfr_pkg::pixel_t           pix,
  output pfr_pkg::rgba_t                 res
);
  import pfr_pkg::*;

  logic [63:0] lo;
  logic [63:0] hi;
  logic [15:0] w;

  assign lo = pix.pixel_low;
  assign hi = pix.pixel_high;
  assign w  = lo[15:0];

  always_comb begin
    res.red   = 32'h0;
    res.green = 32'h0;
    res.blue  = 32'h0;
    res.alpha = ONE_BITS;
    unique case (fmt)
      FMT_GRAY8: begin
        res.red   = DIV255_TBL[lo[7:0]];
        res.green = DIV255_TBL[lo[7:0]];
        res.blue  = DIV255_TBL[lo[7:0]];
      end
      FMT_GRAY_ALPHA: begin
        res.red   = DIV255_TBL[lo[7:0]];
        res.green = DIV255_TBL[lo[7:0]];
        res.blue  = DIV255_TBL[lo[7:0]];
        res.alpha = DIV255_TBL[lo[15:8]];
      end
      FMT_R5G6B5: begin
        res.red   = SCALE31_TBL[{1'b0, w[15:11]}];
        res.green = SCALE63_TBL[w[10:5]];
        res.blue  = SCALE31_TBL[{1'b0, w[4:0]}];
      end
      FMT_R8G8B8: begin
        res.red   = DIV255_TBL[lo[7:0]];
        res.green = DIV255_TBL[lo[15:8]];
        res.blue  = DIV255_TBL[lo[23:16]];
      end
      FMT_R5G5B5A1: begin
        res.red   = SCALE31_TBL[{1'b0, w[15:11]}];
        res.green = SCALE31_TBL[{1'b0, w[10:6]}];
        res.blue  = SCALE31_TBL[{1'b0, w[5:1]}];
        res.alpha = w[0] ? ONE_BITS : 32'h0;
      end
      FMT_R4G4B4A4: begin
        res.red   = SCALE15_TBL[{2'b00, w[15:12]}];
        res.green = SCALE15_TBL[{2'b00, w[11:8]}];
        res.blue  = SCALE15_TBL[{2'b00, w[7:4]}];
        res.alpha = SCALE15_TBL[{2'b00, w[3:0]}];
      end
      FMT_RGBA8: begin
        res.red   = DIV255_TBL[lo[7:0]];
        res.green = DIV255_TBL[lo[15:8]];
        res.blue  = DIV255_TBL[lo[23:16]];
        res.alpha = DIV255_TBL[lo[31:24]];
      end
      FMT_R32: res.red = lo[31:0];
      FMT_RGB32: begin
        res.red   = lo[31:0];
        res.green = lo[63:32];
        res.blue  = hi[31:0];
      end
      FMT_RGBA32: begin
        res.red   = lo[31:0];
        res.green = lo[63:32];
        res.blue  = hi[31:0];
        res.alpha = hi[63:32];
      end
      FMT_R16: res.red = half_to_single(w);
      FMT_RGB16: begin
        res.red   = half_to_single(w);
        res.green = half_to_single(lo[31:16]);
        res.blue  = half_to_single(lo[47:32]);
      end
      FMT_RGBA16: begin
        res.red   = half_to_single(w);
        res.green = half_to_single(lo[31:16]);
        res.blue  = half_to_single(lo[47:32]);
        res.alpha = half_to_single(lo[63:48]);
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire

>>> hw/rtl/pfr_checker.sv
// Port-level checks for the pixel format unpacker, bound to the top level.
`default_nettype none
module pfr_checker (
  input wire logic           clk,
  input wire logic           rst,
  input wire logic           in_ready,
  input wire logic           out_valid,
  input wire logic           out_ready,
  input wire pfr_pkg::rgba_t out_data
);
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  a_ready_when_drain: assert property (@(posedge clk) disable iff (rst)
    out_ready |-> in_ready)
    else $error("input stalled while output drains");
endmodule

bind pixel_format_to_rgba_float pfr_checker u_pfr_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
`default_nettype wire

>>> verif/pixel_format_to_rgba_float_tb.sv
// Testbench for the pixel format unpacker: exact float prediction, random traffic, stalls.
`default_nettype none

// Holds the RGBA values that the pixels in flight must produce.
class rgba_scoreboard;
  pfr_pkg::rgba_t want_q[$];
  logic [3:0]     fmt;
  int             errors;
  int             n_checked;
  bit [63:0]      rcp_mant [3];
  int             rcp_exp  [3];

  function new();
    int    dv [3];
    bit [31:0] rc;
    dv = '{15, 31, 63};
    fmt = pfr_pkg::FMT_GRAY8;
    errors = 0;
    n_checked = 0;
    // single-precision 1/n, kept as integer mantissa and unbiased exponent
    for (int i = 0; i < 3; i++) begin
      rc = round_single(sticky_div(64'h1 << 40, dv[i]), 40);
      rcp_mant[i] = {40'h0, 1'b1, rc[22:0]};
      rcp_exp[i] = int'(rc[30:23]) - 127;
    end
  endfunction

  // quotient with a sticky lsb for inexact division
  function bit [63:0] sticky_div(bit [63:0] num, int d);
    bit [63:0] q;
    q = num / d;
    if (num % d != 0) q[0] = 1'b1;
    return q;
  endfunction

  // x * 2^-e rounded to nearest even; normal range only
  function bit [31:0] round_single(bit [63:0] x, int e);
    int        p;
    int        sh;
    bit [63:0] mant;
    bit [63:0] lost;
    bit [63:0] halfway;
    p = 63;
    while (p >= 0 && !x[p]) p--;
    if (p < 0) return 32'h0;
    if (p <= 23) begin
      mant = x << (23 - p);
    end else begin
      sh = p - 23;
      mant = x >> sh;
      lost = x & ((64'h1 << sh) - 1);
      halfway = 64'h1 << (sh - 1);
      if (lost > halfway || (lost == halfway && mant[0])) mant++;
      if (mant[24]) begin
        mant = mant >> 1;
        p++;
      end
    end
    return {1'b0, 8'(p - e + 127), mant[22:0]};
  endfunction

  function bit [31:0] byte_norm(bit [7:0] v);
    return round_single(sticky_div(64'(v) << 40, 255), 40);
  endfunction

  // idx 0: 4-bit, 1: 5-bit, 2: 6-bit field
  function bit [31:0] field_norm(bit [5:0] v, int idx);
    return round_single(64'(v) * rcp_mant[idx], 23 - rcp_exp[idx]);
  endfunction

  function bit [31:0] widen_half(bit [15:0] h);
    bit [31:0] r;
    bit [22:0] m;
    int        p;
    m = {h[9:0], 13'h0};
    r = {h[15], 31'h0};
    if (h[14:10] != 0) begin
      r[30:23] = 8'(h[14:10]) + 8'd112;
      r[22:0] = m;
    end else if (m != 0) begin
      p = 22;
      while (!m[p]) p--;
      r[30:23] = 8'(p + 90);
      r[22:0] = (m << (23 - p)) & 23'h7FE000;
    end
    return r;
  endfunction

  function void note(pfr_pkg::pixel_t px);
    pfr_pkg::rgba_t e;
    bit [63:0]      lo;
    bit [63:0]      hi;
    bit [15:0]      w;
    lo = px.pixel_low;
    hi = px.pixel_high;
    w = lo[15:0];
    e = '{alpha: pfr_pkg::ONE_BITS, blue: 0, green: 0, red: 0};
    case (fmt)
      pfr_pkg::FMT_GRAY8: begin
        e.red = byte_norm(lo[7:0]); e.green = e.red; e.blue = e.red;
      end
      pfr_pkg::FMT_GRAY_ALPHA: begin
        e.red = byte_norm(lo[7:0]); e.green = e.red; e.blue = e.red;
        e.alpha = byte_norm(lo[15:8]);
      end
      pfr_pkg::FMT_R5G6B5: begin
        e.red = field_norm(w[15:11], 1);
        e.green = field_norm(w[10:5], 2);
        e.blue = field_norm(w[4:0], 1);
      end
      pfr_pkg::FMT_R8G8B8: begin
        e.red = byte_norm(lo[7:0]);
        e.green = byte_norm(lo[15:8]);
        e.blue = byte_norm(lo[23:16]);
      end
      pfr_pkg::FMT_R5G5B5A1: begin
        e.red = field_norm(w[15:11], 1);
        e.green = field_norm(w[10:6], 1);
        e.blue = field_norm(w[5:1], 1);
        e.alpha = w[0] ? pfr_pkg::ONE_BITS : 32'h0;
      end
      pfr_pkg::FMT_R4G4B4A4: begin
        e.red = field_norm(w[15:12], 0);
        e.green = field_norm(w[11:8], 0);
        e.blue = field_norm(w[7:4], 0);
        e.alpha = field_norm(w[3:0], 0);
      end
      pfr_pkg::FMT_RGBA8: begin
        e.red = byte_norm(lo[7:0]);
        e.green = byte_norm(lo[15:8]);
        e.blue = byte_norm(lo[23:16]);
        e.alpha = byte_norm(lo[31:24]);
      end
      pfr_pkg::FMT_R32: e.red = lo[31:0];
      pfr_pkg::FMT_RGB32: begin
        e.red = lo[31:0]; e.green = lo[63:32]; e.blue = hi[31:0];
      end
      pfr_pkg::FMT_RGBA32: begin
        e.red = lo[31:0]; e.green = lo[63:32]; e.blue = hi[31:0]; e.alpha = hi[63:32];
      end
      pfr_pkg::FMT_R16: e.red = widen_half(w);
      pfr_pkg::FMT_RGB16: begin
        e.red = widen_half(w);
        e.green = widen_half(lo[31:16]);
        e.blue = widen_half(lo[47:32]);
      end
      pfr_pkg::FMT_RGBA16: begin
        e.red = widen_half(w);
        e.green = widen_half(lo[31:16]);
        e.blue = widen_half(lo[47:32]);
        e.alpha = widen_half(lo[63:48]);
      end
      default: ;
    endcase
    want_q.push_back(e);
  endfunction

  function void check(pfr_pkg::rgba_t got);
    pfr_pkg::rgba_t e;
    n_checked++;
    if (want_q.size() == 0) begin
      $error("result with no pixel outstanding: %h", got);
      errors++;
      return;
    end
    e = want_q.pop_front();
    if (got.red !== e.red) begin
      $error("red: expected %h, got %h", e.red, got.red); errors++;
    end
    if (got.green !== e.green) begin
      $error("green: expected %h, got %h", e.green, got.green); errors++;
    end
    if (got.blue !== e.blue) begin
      $error("blue: expected %h, got %h", e.blue, got.blue); errors++;
    end
    if (got.alpha !== e.alpha) begin
      $error("alpha: expected %h, got %h", e.alpha, got.alpha); errors++;
    end
  endfunction
endclass

module pixel_format_to_rgba_float_tb;
  import pfr_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int LONG_HOLD = 60;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  pixel_t     in_data;
  logic       out_valid;
  logic       out_ready;
  rgba_t      out_data;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [3:0] cfg_data;

  rgba_scoreboard sb;
  bit quiet_tail;   // final phase: no idling on either side
  bit hold_done;
  int n_pixels;
  int n_cfg;

  pixel_format_to_rgba_float dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Drive one pixel; optional idle burst first. Called and returns at a rising edge.
  // Handshake is sampled at the falling edge, where everything has settled.
  task automatic send_pixel(pixel_t px);
    bit fire;
    if (!quiet_tail && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= px;
    do begin
      @(negedge clk);
      fire = in_ready;
      @(posedge clk);
    end while (!fire);
    sb.note(px);
    n_pixels++;
  endtask

  // Close the input and wait until every outstanding result has come back.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.want_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);   // margin behind the two-stage pipeline
  endtask

  task automatic write_format(logic [3:0] f);
    bit fire;
    cfg_valid <= 1'b1;
    cfg_data <= f;
    do begin
      @(negedge clk);
      fire = cfg_ready;
      @(posedge clk);
    end while (!fire);
    cfg_valid <= 1'b0;
    sb.fmt = f;
    n_cfg++;
  endtask

  // Random half with a fair share of zero-exponent (denormal) and all-ones exponent codes.
  function automatic logic [15:0] rand_half();
    logic [15:0] h;
    h = 16'($urandom);
    case ($urandom_range(0, 5))
      0: h[14:10] = 5'h00;
      1: h[14:10] = 5'h1F;
      default: ;
    endcase
    return h;
  endfunction

  function automatic pixel_t rand_pixel(logic [3:0] f);
    pixel_t px;
    px.pixel_low = {$urandom, $urandom};
    px.pixel_high = {$urandom, $urandom};
    if (f == FMT_R16 || f == FMT_RGB16 || f == FMT_RGBA16)
      px.pixel_low = {rand_half(), rand_half(), rand_half(), rand_half()};
    return px;
  endfunction

  // Result side: random stalls, plus one long hold so the pipeline backs up into in_ready.
  initial begin
    out_ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!hold_done && sb.n_checked >= 120) begin
        hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(negedge clk);
      if (out_valid) sb.check(out_data);
      @(posedge clk);
    end
  end

  // Watchdog: cycles with no transfer on any channel.
  initial begin
    int idle;
    idle = 0;
    forever begin
      @(negedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready) || rst)
        idle = 0;
      else
        idle++;
      if (idle >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    logic [3:0] order [$];
    int         per_phase;
    sb = new();
    quiet_tail = 1'b0;
    hold_done = 1'b0;
    n_pixels = 0;
    n_cfg = 0;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset format (gray8) first, byte extremes with junk above.
    send_pixel('{pixel_high: '1, pixel_low: 64'hFFFF_FFFF_FFFF_FF00});
    send_pixel('{pixel_high: '0, pixel_low: 64'h0000_0000_0000_00FF});
    drain();
    write_format(FMT_GRAY_ALPHA);
    send_pixel('{pixel_high: '0, pixel_low: 64'h0000_0000_0000_FF00});
    drain();
    write_format(FMT_R5G5B5A1);
    send_pixel('{pixel_high: '0, pixel_low: 64'h0000_0000_0000_FFFF});
    send_pixel('{pixel_high: '1, pixel_low: 64'hFFFF_FFFF_FFFF_0000});
    drain();
    write_format(FMT_R4G4B4A4);
    send_pixel('{pixel_high: '0, pixel_low: 64'h0000_0000_0000_F0F0});
    drain();
    write_format(FMT_RGBA32);
    send_pixel('{pixel_high: 64'h7F80_0000_FFFF_FFFF, pixel_low: 64'h8000_0000_7FC0_0001});
    drain();
    // half corners: zero, negative zero, smallest and largest denormal, all-ones exponent
    write_format(FMT_RGBA16);
    send_pixel('{pixel_high: '0, pixel_low: 64'h03FF_0001_8000_0000});
    send_pixel('{pixel_high: '0, pixel_low: 64'hFFFF_7C00_83FF_FBFF});
    send_pixel('{pixel_high: '0, pixel_low: 64'h0400_3C00_8001_0200});
    drain();
    // unused codes: no format, constant output
    write_format(4'hF);
    send_pixel('{pixel_high: '1, pixel_low: '1});
    drain();
    write_format(4'hD);
    send_pixel('{pixel_high: '0, pixel_low: 64'h1234_5678_9ABC_DEF0});
    drain();

    // Random phases over every code, extremes included; the last phase runs without idling.
    for (int f = 0; f < 16; f++) order.push_back(4'(f));
    order.push_back(FMT_RGBA16);
    order.push_back(FMT_GRAY8);
    per_phase = 30;
    foreach (order[i]) begin
      quiet_tail = (i == order.size() - 1);
      write_format(order[i]);
      repeat (per_phase) send_pixel(rand_pixel(order[i]));
      drain();
    end

    $display("covered %0d pixels over %0d format writes, codes 0 to 15", n_pixels, n_cfg);
    $display("results checked: %0d, long receiver hold exercised: %0d", sb.n_checked, hold_done);
    if (sb.errors == 0 && sb.want_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire
